// ===== design/pidf_pkg.sv =====
package pidf_pkg;

   localparam int DATA_W    = 32;
   localparam int WRAP_W    = 31;
   localparam int INT_W     = 48;
   localparam int ACC_W     = 61;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P   = 3'd0,
      CSR_GAIN_I   = 3'd1,
      CSR_GAIN_D   = 3'd2,
      CSR_GAIN_V   = 3'd3,
      CSR_GAIN_A   = 3'd4,
      CSR_WRAP     = 3'd5,
      CSR_OUT_MIN  = 3'd6,
      CSR_OUT_MAX  = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR,
      OP_MOD_START,
      OP_WRAP,
      OP_SAT,
      OP_PRIME,
      OP_CLEAR,
      OP_INT_SUM,
      OP_INT_MUL,
      OP_INT_ACC,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_ADD,
      OP_MUL_ACC,
      OP_DTERM,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      TERM_P,
      TERM_I,
      TERM_V,
      TERM_A,
      TERM_D
   } term_type;

   typedef struct packed {
      op_type   op;
      term_type term;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic need_wrap;
      logic div_busy;
      logic primed;
   } status_type;

endpackage

// ===== design/pidf_if.sv =====
interface pidf_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic signed [pidf_pkg::DATA_W-1:0] target;
   logic signed [pidf_pkg::DATA_W-1:0] position;
   logic signed [pidf_pkg::DATA_W-1:0] velocity;
   logic signed [pidf_pkg::DATA_W-1:0] acceleration;
   logic signed [pidf_pkg::DATA_W-1:0] feedforward;
   logic        [pidf_pkg::DATA_W-1:0] elapsed;

   modport source (output valid, req_type, target, position, velocity, acceleration,
                   feedforward, elapsed, input ready);
   modport sink (input valid, req_type, target, position, velocity, acceleration,
                 feedforward, elapsed, output ready);
endinterface

interface pidf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pidf_pkg::DATA_W-1:0] drive;
   logic                              primed_only;

   modport source (output valid, drive, primed_only, input ready);
   modport sink (input valid, drive, primed_only, output ready);
endinterface

interface pidf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pidf_pkg::CSR_IDX_W-1:0]      index;
   logic [pidf_pkg::DATA_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pidf_div.sv =====
module pidf_div #(
   parameter int DIVIDEND_W = 49,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/pidf_ctrl.sv =====
module pidf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   input  pidf_pkg::status_type status,
   output pidf_pkg::cmd_type    cmd
);

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_ERR     = 19'h00002,
      S_CHK     = 19'h00004,
      S_MOD     = 19'h00008,
      S_WRAP    = 19'h00010,
      S_SAT     = 19'h00020,
      S_PRIME   = 19'h00040,
      S_CLR     = 19'h00080,
      S_INT_SUM = 19'h00100,
      S_INT_MUL = 19'h00200,
      S_INT_ACC = 19'h00400,
      S_MUL_LO  = 19'h00800,
      S_MUL_HI  = 19'h01000,
      S_MUL_ADD = 19'h02000,
      S_MUL_ACC = 19'h04000,
      S_DWAIT   = 19'h08000,
      S_DTERM   = 19'h10000,
      S_FINISH  = 19'h20000,
      S_OUT     = 19'h40000
   } state_type;

   state_type          state_ff, state_in;
   pidf_pkg::term_type term_ff, term_in, term_next;

   always_comb begin
      unique case (term_ff)
         pidf_pkg::TERM_P: term_next = pidf_pkg::TERM_I;
         pidf_pkg::TERM_I: term_next = pidf_pkg::TERM_V;
         pidf_pkg::TERM_V: term_next = pidf_pkg::TERM_A;
         default:          term_next = pidf_pkg::TERM_D;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      cmd.op   = pidf_pkg::OP_NONE;
      cmd.term = term_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = pidf_pkg::OP_LOAD;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op   = pidf_pkg::OP_ERR;
            state_in = status.is_clear ? S_CLR : S_CHK;
         end
         S_CHK: begin
            if (status.need_wrap) begin
               cmd.op   = pidf_pkg::OP_MOD_START;
               state_in = S_MOD;
            end else begin
               state_in = S_SAT;
            end
         end
         S_MOD: begin
            if (!status.div_busy) state_in = S_WRAP;
         end
         S_WRAP: begin
            cmd.op   = pidf_pkg::OP_WRAP;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.op   = pidf_pkg::OP_SAT;
            state_in = status.primed ? S_INT_SUM : S_PRIME;
         end
         S_PRIME: begin
            cmd.op   = pidf_pkg::OP_PRIME;
            state_in = S_OUT;
         end
         S_CLR: begin
            cmd.op   = pidf_pkg::OP_CLEAR;
            state_in = S_OUT;
         end
         S_INT_SUM: begin
            cmd.op   = pidf_pkg::OP_INT_SUM;
            state_in = S_INT_MUL;
         end
         S_INT_MUL: begin
            cmd.op   = pidf_pkg::OP_INT_MUL;
            state_in = S_INT_ACC;
         end
         S_INT_ACC: begin
            cmd.op   = pidf_pkg::OP_INT_ACC;
            term_in  = pidf_pkg::TERM_P;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.op   = pidf_pkg::OP_MUL_LO;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.op   = pidf_pkg::OP_MUL_HI;
            state_in = S_MUL_ADD;
         end
         S_MUL_ADD: begin
            cmd.op   = pidf_pkg::OP_MUL_ADD;
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            cmd.op = pidf_pkg::OP_MUL_ACC;
            priority if (term_ff == pidf_pkg::TERM_D) begin
               state_in = S_FINISH;
            end else if (term_ff == pidf_pkg::TERM_A) begin
               state_in = S_DWAIT;
            end else begin
               term_in  = term_next;
               state_in = S_MUL_LO;
            end
         end
         S_DWAIT: begin
            if (!status.div_busy) state_in = S_DTERM;
         end
         S_DTERM: begin
            cmd.op   = pidf_pkg::OP_DTERM;
            term_in  = pidf_pkg::TERM_D;
            state_in = S_MUL_LO;
         end
         S_FINISH: begin
            cmd.op   = pidf_pkg::OP_FINISH;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff  <= pidf_pkg::TERM_P;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

endmodule

// ===== design/pidf_datapath.sv =====
module pidf_datapath #(
   parameter int STATIC_FRICTION = 0,
   parameter int FRAC_BITS       = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pidf_pkg::cmd_type                   cmd,
   output pidf_pkg::status_type                status,
   input  logic                                csr_write,
   input  logic [pidf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidf_pkg::DATA_W-1:0]         csr_data,
   input  logic                                req_type,
   input  logic signed [pidf_pkg::DATA_W-1:0]  target,
   input  logic signed [pidf_pkg::DATA_W-1:0]  position,
   input  logic signed [pidf_pkg::DATA_W-1:0]  velocity,
   input  logic signed [pidf_pkg::DATA_W-1:0]  acceleration,
   input  logic signed [pidf_pkg::DATA_W-1:0]  feedforward,
   input  logic        [pidf_pkg::DATA_W-1:0]  elapsed,
   output logic signed [pidf_pkg::DATA_W-1:0]  drive,
   output logic                                primed_only
);

   localparam int DW    = pidf_pkg::DATA_W;
   localparam int IW    = pidf_pkg::INT_W;
   localparam int AW    = pidf_pkg::ACC_W;
   localparam int DIV_W = DW + 1 + FRAC_BITS;
   localparam int DT_W  = DIV_W + 2;
   localparam int PW    = 80;
   localparam logic [PW-1:0] PROD_CAP = PW'(1) << 56;

   // configuration
   logic signed [DW-1:0]  gain_p_ff, gain_i_ff, gain_d_ff, gain_v_ff, gain_a_ff;
   logic [pidf_pkg::WRAP_W-1:0] wrap_ff;
   logic signed [DW-1:0]  out_min_ff, out_max_ff;

   // latched word
   logic                  type_ff;
   logic signed [DW-1:0]  target_ff, position_ff, velocity_ff, accel_ff, ffwd_ff;
   logic [DW-1:0]         elapsed_ff;

   // state and working registers
   logic signed [DW:0]    e_ff;
   logic signed [DW-1:0]  err_ff;
   logic signed [IW-1:0]  integral_ff, integral_in;
   logic signed [DW-1:0]  prev_ff;
   logic                  primed_ff;
   logic [DW:0]           mag_s_ff;
   logic                  s_neg_ff, diff_neg_ff, neg_ff;
   logic [63:0]           prod_ff;
   logic [PW-1:0]         pacc_ff;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic signed [IW-1:0]  dterm_ff, dterm_in;
   logic signed [DW-1:0]  drive_ff, drive_in;
   logic                  primed_only_ff;

   // divider
   logic                  div_start, div_busy;
   logic [DIV_W-1:0]      div_dividend, div_quotient;
   logic [DW-1:0]         div_divisor, div_remainder;

   // shared multiplier
   logic [DW-1:0]         mul_a, mul_b;
   logic [63:0]           mul_p;

   logic [DW:0]           mag_e, mag_diff, mag_s;
   logic signed [DW:0]    s_val, diff_val, wrap_res;
   logic                  wrap_gt;
   logic signed [DW-1:0]  op_a;
   logic signed [IW-1:0]  op_b;
   logic [DW-1:0]         ua;
   logic [IW-1:0]         ub;
   logic [63:0]           int_m;
   logic [63:0]           int_q;
   logic signed [65:0]    int_sum;
   logic [PW-1:0]         psh;
   logic [56:0]           pm;
   logic [DIV_W-1:0]      qd;
   logic signed [DIV_W:0] sq;
   logic signed [DT_W-1:0] dt_sum;
   logic signed [AW:0]    fin_v, fin_fr, fin_min, fin_max;

   pidf_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      mag_e    = e_ff[DW] ? (~e_ff + 1'b1) : e_ff;
      s_val    = {err_ff[DW-1], err_ff} + {prev_ff[DW-1], prev_ff};
      diff_val = {err_ff[DW-1], err_ff} - {prev_ff[DW-1], prev_ff};
      mag_s    = s_val[DW] ? (~s_val + 1'b1) : s_val;
      mag_diff = diff_val[DW] ? (~diff_val + 1'b1) : diff_val;

      div_start    = (cmd.op == pidf_pkg::OP_MOD_START) ||
                     ((cmd.op == pidf_pkg::OP_INT_SUM) && (elapsed_ff != '0));
      if (cmd.op == pidf_pkg::OP_MOD_START) begin
         div_dividend = DIV_W'(mag_e);
         div_divisor  = {1'b0, wrap_ff};
      end else begin
         div_dividend = {mag_diff, {FRAC_BITS{1'b0}}};
         div_divisor  = elapsed_ff;
      end

      // fold the remainder into the half range, keep a tie as it is
      wrap_gt  = {div_remainder, 1'b0} > {2'b00, wrap_ff};
      wrap_res = wrap_gt ? $signed({1'b0, div_remainder} - {2'b00, wrap_ff})
                         : $signed({1'b0, div_remainder});

      case (cmd.term)
         pidf_pkg::TERM_P: begin op_a = gain_p_ff; op_b = IW'(err_ff);      end
         pidf_pkg::TERM_I: begin op_a = gain_i_ff; op_b = integral_ff;      end
         pidf_pkg::TERM_V: begin op_a = gain_v_ff; op_b = IW'(velocity_ff); end
         pidf_pkg::TERM_A: begin op_a = gain_a_ff; op_b = IW'(accel_ff);    end
         default:          begin op_a = gain_d_ff; op_b = dterm_ff;         end
      endcase
      ua = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
      ub = op_b[IW-1] ? (~op_b + 1'b1) : op_b;

      unique case (cmd.op)
         pidf_pkg::OP_INT_MUL: begin mul_a = mag_s_ff[DW-1:0]; mul_b = elapsed_ff; end
         pidf_pkg::OP_MUL_HI:  begin mul_a = ua; mul_b = {16'd0, ub[IW-1:32]};     end
         default:              begin mul_a = ua; mul_b = ub[31:0];                 end
      endcase
      mul_p = mul_a * mul_b;

      int_m   = prod_ff + (mag_s_ff[DW] ? {elapsed_ff, 32'd0} : 64'd0);
      int_q   = int_m >> (FRAC_BITS + 1);
      int_sum = s_neg_ff ? (66'(integral_ff) - $signed({2'b00, int_q}))
                         : (66'(integral_ff) + $signed({2'b00, int_q}));
      if ((&int_sum[65:IW-1]) || !(|int_sum[65:IW-1]))
         integral_in = int_sum[IW-1:0];
      else
         integral_in = int_sum[65] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};

      psh    = pacc_ff >> FRAC_BITS;
      pm     = (psh > PROD_CAP) ? PROD_CAP[56:0] : psh[56:0];
      acc_in = neg_ff ? (acc_ff - $signed({4'd0, pm})) : (acc_ff + $signed({4'd0, pm}));

      qd     = (elapsed_ff != '0) ? div_quotient : '0;
      sq     = diff_neg_ff ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
      dt_sum = DT_W'(sq) - DT_W'(velocity_ff);
      if ((&dt_sum[DT_W-1:IW-1]) || !(|dt_sum[DT_W-1:IW-1]))
         dterm_in = dt_sum[IW-1:0];
      else
         dterm_in = dt_sum[DT_W-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};

      // add friction away from zero, clamp when bounds are ordered, saturate
      fin_fr  = (AW + 1)'(STATIC_FRICTION);
      fin_min = (AW + 1)'(out_min_ff);
      fin_max = (AW + 1)'(out_max_ff);
      fin_v   = (AW + 1)'(acc_ff);
      if (acc_ff > 0)      fin_v = fin_v + fin_fr;
      else if (acc_ff < 0) fin_v = fin_v - fin_fr;
      if (out_min_ff < out_max_ff) begin
         if (fin_v < fin_min) fin_v = fin_min;
         if (fin_v > fin_max) fin_v = fin_max;
      end
      if ((&fin_v[AW:DW-1]) || !(|fin_v[AW:DW-1]))
         drive_in = fin_v[DW-1:0];
      else
         drive_in = fin_v[AW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         gain_v_ff   <= '0;
         gain_a_ff   <= '0;
         wrap_ff     <= '0;
         out_min_ff  <= {1'b1, {(DW-1){1'b0}}};
         out_max_ff  <= {1'b0, {(DW-1){1'b1}}};
         integral_ff <= '0;
         prev_ff     <= '0;
         primed_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (pidf_pkg::csr_index_type'(csr_index))
               pidf_pkg::CSR_GAIN_P:  gain_p_ff  <= csr_data;
               pidf_pkg::CSR_GAIN_I:  gain_i_ff  <= csr_data;
               pidf_pkg::CSR_GAIN_D:  gain_d_ff  <= csr_data;
               pidf_pkg::CSR_GAIN_V:  gain_v_ff  <= csr_data;
               pidf_pkg::CSR_GAIN_A:  gain_a_ff  <= csr_data;
               pidf_pkg::CSR_WRAP:    wrap_ff    <= csr_data[pidf_pkg::WRAP_W-1:0];
               pidf_pkg::CSR_OUT_MIN: out_min_ff <= csr_data;
               pidf_pkg::CSR_OUT_MAX: out_max_ff <= csr_data;
            endcase
         end
         unique case (cmd.op)
            pidf_pkg::OP_CLEAR: begin
               integral_ff <= '0;
               prev_ff     <= '0;
               primed_ff   <= 1'b0;
            end
            pidf_pkg::OP_PRIME: begin
               prev_ff   <= err_ff;
               primed_ff <= 1'b1;
            end
            pidf_pkg::OP_INT_SUM: prev_ff <= err_ff;
            pidf_pkg::OP_INT_ACC: integral_ff <= integral_in;
            default: ;
         endcase
      end

      unique case (cmd.op)
         pidf_pkg::OP_LOAD: begin
            type_ff     <= req_type;
            target_ff   <= target;
            position_ff <= position;
            velocity_ff <= velocity;
            accel_ff    <= acceleration;
            ffwd_ff     <= feedforward;
            elapsed_ff  <= elapsed;
         end
         pidf_pkg::OP_ERR: e_ff <= {target_ff[DW-1], target_ff} - {position_ff[DW-1], position_ff};
         pidf_pkg::OP_WRAP: e_ff <= e_ff[DW] ? -wrap_res : wrap_res;
         pidf_pkg::OP_SAT: begin
            if (e_ff[DW] != e_ff[DW-1])
               err_ff <= e_ff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            else
               err_ff <= e_ff[DW-1:0];
         end
         pidf_pkg::OP_PRIME, pidf_pkg::OP_CLEAR: begin
            drive_ff       <= '0;
            primed_only_ff <= 1'b1;
         end
         pidf_pkg::OP_INT_SUM: begin
            mag_s_ff    <= mag_s;
            s_neg_ff    <= s_val[DW];
            diff_neg_ff <= diff_val[DW];
            acc_ff      <= AW'(ffwd_ff);
         end
         pidf_pkg::OP_INT_MUL: prod_ff <= mul_p;
         pidf_pkg::OP_MUL_LO: begin
            prod_ff <= mul_p;
            neg_ff  <= op_a[DW-1] ^ op_b[IW-1];
         end
         pidf_pkg::OP_MUL_HI: begin
            prod_ff <= mul_p;
            pacc_ff <= PW'(prod_ff);
         end
         pidf_pkg::OP_MUL_ADD: pacc_ff <= pacc_ff + {prod_ff[47:0], 32'd0};
         pidf_pkg::OP_MUL_ACC: acc_ff <= acc_in;
         pidf_pkg::OP_DTERM:   dterm_ff <= dterm_in;
         pidf_pkg::OP_FINISH: begin
            drive_ff       <= drive_in;
            primed_only_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   assign status.is_clear  = type_ff;
   assign status.need_wrap = (wrap_ff != '0) && ({mag_e, 1'b0} > {3'b000, wrap_ff});
   assign status.div_busy  = div_busy;
   assign status.primed    = primed_ff;
   assign drive            = drive_ff;
   assign primed_only      = primed_only_ff;

endmodule

// ===== design/pidf_controller_step.sv =====
// PID controller step with velocity and acceleration feedforward.
//
// req_if carries one word per control update: req_type (0 update, 1 clear),
// target, position, velocity, acceleration, feedforward and elapsed time.
// rsp_if returns exactly one word per request: drive and primed_only.
// csr_if writes the gains, the wrap span and the output bounds; write it
// only while no request is in flight. It is always ready.
//
// One request is in flight at a time. A clear passes through the error
// and clear states before its result shows, a priming update through
// the error, check, saturation and prime states. A full update forms the
// derivative with the restoring divider, one quotient bit per cycle;
// with zero elapsed the divider is skipped. An error that has to be
// wrapped first runs the divider for the modulo as well. The five gain
// products share one 32x32 multiplier, each in the steps MUL_LO, MUL_HI,
// MUL_ADD and MUL_ACC. The next request is taken the cycle after the
// result is taken.
//
// The result stays on rsp_if until it is taken; req_if.ready stays low
// meanwhile. Reset clears the integral, the last error, the primed flag,
// the gains and the wrap span; the working registers are not reset.
module pidf_controller_step #(
   parameter int STATIC_FRICTION = 0,
   parameter int FRAC_BITS       = 16
) (
   input  logic       clock,
   input  logic       reset,
   pidf_req_if.sink   req_if,
   pidf_rsp_if.source rsp_if,
   pidf_csr_if.sink   csr_if
);

   pidf_pkg::cmd_type    dp_cmd;
   pidf_pkg::status_type dp_status;
   logic                 in_ready, out_valid;

   pidf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_if.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   pidf_datapath #(.STATIC_FRICTION(STATIC_FRICTION), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .csr_write    (csr_if.valid),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .req_type     (req_if.req_type),
      .target       (req_if.target),
      .position     (req_if.position),
      .velocity     (req_if.velocity),
      .acceleration (req_if.acceleration),
      .feedforward  (req_if.feedforward),
      .elapsed      (req_if.elapsed),
      .drive        (rsp_if.drive),
      .primed_only  (rsp_if.primed_only)
   );

   assign req_if.ready = in_ready;
   assign rsp_if.valid = out_valid;
   assign csr_if.ready = 1'b1;

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a result is pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !rsp_if.valid)
      else $error("result shown in the cycle after a request");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == pidf_pkg::OP_MOD_START || dp_cmd.op == pidf_pkg::OP_INT_SUM)
         |-> !dp_status.div_busy)
      else $error("divider restarted while busy");

   a_primed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.primed_only) |-> (rsp_if.drive == '0))
      else $error("priming result with nonzero drive");

endmodule

// ===== tb/pidf_controller_step_tb.sv =====
module pidf_controller_step_tb;

   localparam int FRAC = 16;
   localparam int FRICTION = 0;
   localparam longint CAP56 = longint'(1) <<< 56;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [pidf_pkg::DATA_W-1:0] drive;
      logic                        primed_only;
   } drive_word_type;

   class drive_scoreboard;
      longint kp, ki, kd, kv, ka, out_lo, out_hi;
      longint unsigned span;
      longint err_sum, last_err;
      bit     primed;
      drive_word_type pending[$];
      int     failures;

      function void clear_all();
         kp = 0; ki = 0; kd = 0; kv = 0; ka = 0; span = 0;
         out_lo = -64'sd2147483648; out_hi = 64'sd2147483647;
         err_sum = 0; last_err = 0; primed = 0; failures = 0;
      endfunction

      function longint sat(longint v, int bits);
         longint lim;
         lim = longint'(1) <<< (bits - 1);
         if (v > lim - 1) return lim - 1;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function longint unsigned magn(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint scale(longint g, longint x);
         bit neg;
         longint unsigned ua, ub, lo, hi, m;
         neg = (g < 0) != (x < 0);
         ua = magn(g); ub = magn(x);
         lo = ua * ub[31:0];
         hi = ua * (ub >> 32);
         if (hi > (CAP56 >> (32 - FRAC))) m = CAP56;
         else begin
            m = (hi << (32 - FRAC)) + (lo >> FRAC);
            if (m > CAP56) m = CAP56;
         end
         return neg ? -longint'(m) : longint'(m);
      endfunction

      function longint fold(longint e);
         longint unsigned a, r;
         longint res;
         if (span == 0) return e;
         a = magn(e);
         if (2 * a <= span) return e;
         r = a % span;
         res = (2 * r > span) ? longint'(r) - longint'(span) : longint'(r);
         return e < 0 ? -res : res;
      endfunction

      function void write_reg(pidf_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            pidf_pkg::CSR_GAIN_P: kp = longint'(signed'(v));
            pidf_pkg::CSR_GAIN_I: ki = longint'(signed'(v));
            pidf_pkg::CSR_GAIN_D: kd = longint'(signed'(v));
            pidf_pkg::CSR_GAIN_V: kv = longint'(signed'(v));
            pidf_pkg::CSR_GAIN_A: ka = longint'(signed'(v));
            pidf_pkg::CSR_WRAP: span = 64'(v[30:0]);
            pidf_pkg::CSR_OUT_MIN: out_lo = longint'(signed'(v));
            pidf_pkg::CSR_OUT_MAX: out_hi = longint'(signed'(v));
            default: ;
         endcase
      endfunction

      function void note_request(bit clr, logic [31:0] tg, logic [31:0] ps, logic [31:0] vl,
                                 logic [31:0] ac, logic [31:0] ff, logic [31:0] dt);
         drive_word_type w;
         longint e, s, q, dterm, acc, vel, diff;
         longint unsigned m, dtu;
         vel = longint'(signed'(vl));
         dtu = 64'(dt);
         w.drive = '0; w.primed_only = 1;
         if (clr) begin
            err_sum = 0; last_err = 0; primed = 0;
            pending.push_back(w);
            return;
         end
         e = sat(fold(longint'(signed'(tg)) - longint'(signed'(ps))), 32);
         if (!primed) begin
            last_err = e; primed = 1;
            pending.push_back(w);
            return;
         end
         s = e + last_err;
         m = magn(s) * dtu;
         q = longint'(m >> (FRAC + 1));
         if (s < 0) q = -q;
         err_sum = sat(err_sum + q, 48);
         dterm = 0;
         if (dtu != 0) begin
            diff = e - last_err;
            m = (magn(diff) << FRAC) / dtu;
            dterm = diff < 0 ? -longint'(m) : longint'(m);
         end
         dterm = sat(dterm - vel, 48);
         last_err = e;
         acc = scale(kp, e) + scale(ki, err_sum) + scale(kd, dterm) + scale(kv, vel)
             + scale(ka, longint'(signed'(ac))) + longint'(signed'(ff));
         if (acc > 0) acc += FRICTION;
         else if (acc < 0) acc -= FRICTION;
         if (out_lo < out_hi) begin
            if (acc < out_lo) acc = out_lo;
            if (acc > out_hi) acc = out_hi;
         end
         w.drive = 32'(sat(acc, 32));
         w.primed_only = 0;
         pending.push_back(w);
      endfunction

      function void check_word(logic [31:0] drv, logic po);
         drive_word_type w;
         if (pending.size() == 0) begin
            $error("unexpected word drive=%h primed_only=%b", drv, po);
            failures++;
            return;
         end
         w = pending.pop_front();
         if (drv !== w.drive) begin
            $error("drive: expected %h actual %h", w.drive, drv);
            failures++;
         end
         if (po !== w.primed_only) begin
            $error("primed_only: expected %b actual %b", w.primed_only, po);
            failures++;
         end
      endfunction
   endclass

   logic clock, reset;
   pidf_req_if req_if();
   pidf_rsp_if rsp_if();
   pidf_csr_if csr_if();

   pidf_controller_step #(.STATIC_FRICTION(FRICTION), .FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   drive_scoreboard board = new();
   int cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // Drain the response side with random stalls.
   initial begin
      int g;
      rsp_if.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_if.ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock iff rsp_if.valid);
         board.check_word(rsp_if.drive, rsp_if.primed_only);
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic write_csr(pidf_pkg::csr_index_type idx, logic [31:0] v);
      csr_if.valid <= 1;
      csr_if.index <= idx;
      csr_if.data <= v;
      @(posedge clock iff csr_if.ready);
      board.write_reg(idx, v);
      csr_if.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send(bit clr, logic [31:0] tg, logic [31:0] ps, logic [31:0] vl,
                       logic [31:0] ac, logic [31:0] ff, logic [31:0] dt);
      req_if.valid <= 1;
      req_if.req_type <= clr;
      req_if.target <= tg;
      req_if.position <= ps;
      req_if.velocity <= vl;
      req_if.acceleration <= ac;
      req_if.feedforward <= ff;
      req_if.elapsed <= dt;
      @(posedge clock iff req_if.ready);
      board.note_request(clr, tg, ps, vl, ac, ff, dt);
      req_if.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      if ($urandom_range(0, 7) == 0) return rand_word();
      return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
   endfunction

   function automatic logic [31:0] rand_dt();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom();
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 32'h2_0000);
      endcase
   endfunction

   task automatic random_setting(int k);
      write_csr(pidf_pkg::CSR_GAIN_P, rand_gain());
      write_csr(pidf_pkg::CSR_GAIN_I, rand_gain());
      write_csr(pidf_pkg::CSR_GAIN_D, rand_gain());
      write_csr(pidf_pkg::CSR_GAIN_V, rand_gain());
      write_csr(pidf_pkg::CSR_GAIN_A, rand_gain());
      case (k % 4)
         0: write_csr(pidf_pkg::CSR_WRAP, 0);
         1: write_csr(pidf_pkg::CSR_WRAP, 32'h7FFF_FFFF);
         default: write_csr(pidf_pkg::CSR_WRAP, $urandom_range(1, 32'h0100_0000));
      endcase
      case (k % 3)
         0: begin
            write_csr(pidf_pkg::CSR_OUT_MIN, 32'h8000_0000);
            write_csr(pidf_pkg::CSR_OUT_MAX, 32'h7FFF_FFFF);
         end
         1: begin
            write_csr(pidf_pkg::CSR_OUT_MIN, -($urandom_range(0, 32'h10_0000)));
            write_csr(pidf_pkg::CSR_OUT_MAX, $urandom_range(0, 32'h10_0000));
         end
         default: begin
            write_csr(pidf_pkg::CSR_OUT_MIN, $urandom_range(0, 32'h10_0000));
            write_csr(pidf_pkg::CSR_OUT_MAX, -($urandom_range(0, 32'h10_0000)));
         end
      endcase
   endtask

   initial begin
      int g;
      board.clear_all();
      reset = 1;
      req_if.valid = 0; req_if.req_type = 0; req_if.target = 0; req_if.position = 0;
      req_if.velocity = 0; req_if.acceleration = 0; req_if.feedforward = 0;
      req_if.elapsed = 0;
      csr_if.valid = 0; csr_if.index = 0; csr_if.data = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: priming, extremes, zero elapsed, wrap tie, clear.
      write_csr(pidf_pkg::CSR_GAIN_P, 32'h0001_0000);
      write_csr(pidf_pkg::CSR_GAIN_I, 32'h7FFF_FFFF);
      write_csr(pidf_pkg::CSR_GAIN_D, 32'h8000_0000);
      write_csr(pidf_pkg::CSR_GAIN_V, 32'hFFFF_0000);
      write_csr(pidf_pkg::CSR_GAIN_A, 32'h0000_8000);
      send(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 5);
      send(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'hFFFF_FFFF);
      send(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
           0);
      send(0, 0, 0, 0, 0, 0, 32'h0001_0000);
      send(0, 32'h0001_0000, 0, 0, 0, 0, 1);
      send(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF);
      send(0, 0, 0, 0, 0, 0, 0);
      send(0, 0, 0, 0, 0, 0, 32'h0000_4000);
      drain();
      write_csr(pidf_pkg::CSR_GAIN_I, 0);
      write_csr(pidf_pkg::CSR_WRAP, 32'h0010_0000);
      write_csr(pidf_pkg::CSR_OUT_MIN, 32'hFFFF_0000);
      write_csr(pidf_pkg::CSR_OUT_MAX, 32'h0001_0000);
      send(0, 32'h0008_0000, 0, 0, 0, 0, 32'h0001_0000);
      send(0, 32'hFFF8_0000, 0, 0, 0, 0, 32'h0001_0000);
      send(0, 32'h0123_4567, 32'hFEDC_BA98, 0, 0, 0, 32'h0000_0100);
      send(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000);
      drain();
      write_csr(pidf_pkg::CSR_WRAP, 32'h7FFF_FFFF);
      write_csr(pidf_pkg::CSR_OUT_MIN, 32'h0001_0000);
      write_csr(pidf_pkg::CSR_OUT_MAX, 32'h0001_0000);
      send(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h0001_0000);
      send(0, 32'h4000_0000, 32'hC000_0000, 0, 0, 0, 32'h0002_0000);
      drain();

      // Random: mostly update runs, some clears.
      for (int k = 0; k < 12; k++) begin
         random_setting(k);
         for (int n = 0; n < 36; n++) begin
            g = gap_len();
            repeat (g) @(posedge clock);
            if ($urandom_range(0, 19) == 0)
               send(1, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_dt());
            else if ($urandom_range(0, 1))
               send(0, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_dt());
            else
               send(0, $urandom_range(0, 32'h20_0000), $urandom_range(0, 32'h20_0000),
                    $urandom_range(0, 32'h4_0000) - 32'h2_0000,
                    $urandom_range(0, 32'h4_0000) - 32'h2_0000,
                    $urandom_range(0, 32'h4_0000) - 32'h2_0000, rand_dt());
            if (n == 18) drain();
         end
         drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (board.failures == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
